// File: hw/rtl/stepper_step_sequencer_defines.svh
// assertion macros for the stepper sequencer
`ifndef STEPPER_STEP_SEQUENCER_DEFINES_SVH
`define STEPPER_STEP_SEQUENCER_DEFINES_SVH

// same-cycle implication, checked on clk and disabled in reset
`define STPSEQ_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stepper sequencer check failed");

// next-cycle implication, checked on clk and disabled in reset
`define STPSEQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stepper sequencer check failed");

`endif

// File: hw/rtl/stpseq_pkg.sv
// shared types, constants and coil table for the stepper sequencer
`default_nettype none

package stpseq_pkg;

    localparam int SPR_W     = 13;
    localparam int SPD_W     = 10;
    localparam int MOVE_W    = 21;
    localparam int ELAPSED_W = 26;
    localparam int OP_W      = 2;

    localparam int DEF_MAX_STEPS_PER_REV = 4096;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};
    localparam int US_PER_MINUTE = 60 * 1000 * 1000;
    localparam logic [ELAPSED_W-1:0] DIVIDEND = ELAPSED_W'(US_PER_MINUTE);

    localparam int RESET_SPR   = 200;
    localparam int RESET_SPEED = 1;

    // register indexes on the config port
    localparam logic REG_STEPS_PER_REV = 1'b0;
    localparam logic REG_SPEED_RPM     = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 2'd0,
        OP_MOVE   = 2'd1,
        OP_ENABLE = 2'd2
    } op_t;

    // full-step drive pattern for position mod 4
    function automatic logic [3:0] coil_of(input logic [1:0] phase);
        logic [3:0] pat;
        case (phase)
            2'd0:    pat = 4'b0110;
            2'd1:    pat = 4'b0101;
            2'd2:    pat = 4'b1001;
            default: pat = 4'b1010;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/stepper_step_sequencer.sv
// Stepper sequencer top level: the result beat is registered, valid in the cycle after
// the input beat. Throughput is one item per cycle while the result is taken and no
// delay is being derived; the result register frees itself when taken. Each config
// write recomputes the step delay with a multiply and a restoring divide, and the
// input is stalled meanwhile. Reset (rst_n low, async) resets all control state and
// loads the reset config's delay directly, so items are accepted right after reset.
`default_nettype none

`include "stepper_step_sequencer_defines.svh"

module stepper_step_sequencer
    import stpseq_pkg::*;
#(
    parameter int MAX_STEPS_PER_REV = DEF_MAX_STEPS_PER_REV,
    parameter int IDX_W = $clog2(MAX_STEPS_PER_REV)
)(
    input  wire                    clk,
    input  wire                    rst_n,
    // input channel
    input  wire                    in_valid,
    output logic                   in_ready,
    input  wire  [OP_W-1:0]        operation,
    input  wire  signed [MOVE_W-1:0] move_steps,
    input  wire                    enable_value,
    // result channel
    output logic                   out_valid,
    input  wire                    out_ready,
    output logic [3:0]             coil_pattern,
    output logic                   coils_enabled,
    output logic                   step_taken,
    output logic                   busy_res,
    output logic [IDX_W-1:0]       position,
    output logic                   command_rejected,
    // config port
    input  wire                    psel,
    input  wire                    penable,
    input  wire                    pwrite,
    input  wire  [2:0]             paddr,
    input  wire  [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int NW   = $clog2(MAX_STEPS_PER_REV + 1);
    localparam int CW   = (SPR_W > NW) ? SPR_W : NW;
    localparam int DIVW = NW + SPD_W;
    localparam int DCNT_W = $clog2(ELAPSED_W);
    localparam int RESET_WRAP =
        (RESET_SPR > MAX_STEPS_PER_REV) ? MAX_STEPS_PER_REV : RESET_SPR;
    localparam int RESET_DELAY = US_PER_MINUTE / RESET_WRAP / RESET_SPEED;

    // config registers
    logic [SPR_W-1:0] spr_reg;
    logic [SPD_W-1:0] speed_reg;

    // sequencer state
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic [ELAPSED_W-1:0] delay_reg;
    logic [MOVE_W-1:0]    remaining_reg, remaining_next;
    logic [IDX_W-1:0]     index_reg, index_next;
    logic                 forward_reg, forward_next;
    logic [3:0]           coil_reg, coil_next;
    logic                 enable_reg, enable_next;
    logic                 step_next, reject_next;

    // result register
    logic                 out_valid_reg;
    logic [3:0]           res_coil_reg;
    logic                 res_enable_reg;
    logic                 res_step_reg;
    logic                 res_busy_reg;
    logic [IDX_W-1:0]     res_pos_reg;
    logic                 res_reject_reg;

    // delay divider
    logic                 div_start_reg;
    logic                 div_busy_reg;
    logic [DCNT_W-1:0]    div_cnt_reg;
    logic [DIVW-1:0]      divisor_reg;
    logic [DIVW-1:0]      rem_reg;
    logic [ELAPSED_W-1:0] quo_reg;
    logic [DIVW:0]        div_trial;
    logic                 div_fit;

    logic                 cfg_write;
    logic                 in_fire;
    logic [CW-1:0]        spr_c;
    logic [CW-1:0]        wrap_c;
    logic [NW-1:0]        wrap_n;
    logic [SPD_W-1:0]     speed_eff;
    logic [IDX_W:0]       idx_inc;
    logic                 neg_move;
    logic [MOVE_W-1:0]    raw_move;

    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign in_ready  = (!out_valid_reg || out_ready) && !div_busy_reg && !div_start_reg;
    assign in_fire   = in_valid && in_ready;

    // register readback
    always_comb
    begin
        case (paddr[2])
            REG_STEPS_PER_REV: prdata = 32'(spr_reg);
            default:           prdata = 32'(speed_reg);
        endcase
    end

    // wrap count clamped to 1..max, speed floored at 1
    always_comb
    begin
        spr_c = CW'(spr_reg);
        if (spr_c == '0)
            wrap_c = CW'(1);
        else if (spr_c > CW'(MAX_STEPS_PER_REV))
            wrap_c = CW'(MAX_STEPS_PER_REV);
        else
            wrap_c = spr_c;
        wrap_n    = wrap_c[NW-1:0];
        speed_eff = (speed_reg == '0) ? SPD_W'(1) : speed_reg;
    end

    // one restoring divide step
    assign div_trial = {rem_reg, quo_reg[ELAPSED_W-1]};
    assign div_fit   = div_trial >= {1'b0, divisor_reg};

    // config writes and delay derivation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spr_reg       <= SPR_W'(RESET_SPR);
            speed_reg     <= SPD_W'(RESET_SPEED);
            delay_reg     <= ELAPSED_W'(RESET_DELAY);
            div_start_reg <= 1'b0;
            div_busy_reg  <= 1'b0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (paddr[2])
                    REG_STEPS_PER_REV: spr_reg   <= pwdata[SPR_W-1:0];
                    default:           speed_reg <= pwdata[SPD_W-1:0];
                endcase
                div_start_reg <= 1'b1;
                div_busy_reg  <= 1'b0;
            end
            else if (div_start_reg)
            begin
                div_start_reg <= 1'b0;
                div_busy_reg  <= 1'b1;
                div_cnt_reg   <= DCNT_W'(ELAPSED_W - 1);
            end
            else if (div_busy_reg)
            begin
                div_cnt_reg <= div_cnt_reg - 1'b1;
                if (div_cnt_reg == '0)
                begin
                    div_busy_reg <= 1'b0;
                    delay_reg    <= {quo_reg[ELAPSED_W-2:0], div_fit};
                end
            end
        end
    end

    // divider datapath: multiply once, then shift one quotient bit a cycle
    always_ff @(posedge clk)
    begin
        if (div_start_reg)
        begin
            divisor_reg <= DIVW'(wrap_n) * DIVW'(speed_eff);
            rem_reg     <= '0;
            quo_reg     <= DIVIDEND;
        end
        else if (div_busy_reg)
        begin
            rem_reg <= div_fit ? DIVW'(div_trial - {1'b0, divisor_reg})
                               : div_trial[DIVW-1:0];
            quo_reg <= {quo_reg[ELAPSED_W-2:0], div_fit};
        end
    end

    // next state for one input item
    always_comb
    begin
        elapsed_next   = elapsed_reg;
        remaining_next = remaining_reg;
        index_next     = index_reg;
        forward_next   = forward_reg;
        coil_next      = coil_reg;
        enable_next    = enable_reg;
        step_next      = 1'b0;
        reject_next    = 1'b0;
        idx_inc        = {1'b0, index_reg} + 1'b1;
        raw_move       = move_steps;
        neg_move       = raw_move[MOVE_W-1];
        case (operation)
            OP_TICK:
            begin
                if (elapsed_reg != ELAPSED_MAX)
                    elapsed_next = elapsed_reg + 1'b1;
                if (remaining_reg != '0 && elapsed_next >= delay_reg)
                begin
                    elapsed_next = '0;
                    if (forward_reg)
                        index_next = ((NW+1)'(idx_inc) >= (NW+1)'(wrap_n))
                                     ? '0 : idx_inc[IDX_W-1:0];
                    else
                        index_next = (index_reg == '0)
                                     ? IDX_W'(wrap_n - NW'(1)) : index_reg - 1'b1;
                    remaining_next = remaining_reg - 1'b1;
                    coil_next      = coil_of(index_next[1:0]);
                    step_next      = 1'b1;
                end
            end
            OP_MOVE:
            begin
                if (remaining_reg != '0)
                    reject_next = 1'b1;
                else
                begin
                    if (raw_move != '0)
                        forward_next = !neg_move;
                    remaining_next = neg_move ? (~raw_move + 1'b1) : raw_move;
                end
            end
            OP_ENABLE:
                enable_next = enable_value;
            default:
                ;
        endcase
    end

    // state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg   <= '0;
            remaining_reg <= '0;
            index_reg     <= '0;
            forward_reg   <= 1'b0;
            coil_reg      <= 4'b0000;
            enable_reg    <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                elapsed_reg   <= elapsed_next;
                remaining_reg <= remaining_next;
                index_reg     <= index_next;
                forward_reg   <= forward_next;
                coil_reg      <= coil_next;
                enable_reg    <= enable_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result beat payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            res_coil_reg   <= coil_next;
            res_enable_reg <= enable_next;
            res_step_reg   <= step_next;
            res_busy_reg   <= remaining_next != '0;
            res_pos_reg    <= index_next;
            res_reject_reg <= reject_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign coil_pattern     = res_coil_reg;
    assign coils_enabled    = res_enable_reg;
    assign step_taken       = res_step_reg;
    assign busy_res         = res_busy_reg;
    assign position         = res_pos_reg;
    assign command_rejected = res_reject_reg;

    // no beat is taken while the delay is being derived
    `STPSEQ_ASSERT_IMPL(a_stall_on_div, div_busy_reg || div_start_reg, !in_ready)
    // a step always drives one of the four full-step patterns
    `STPSEQ_ASSERT_IMPL(a_step_pattern, out_valid_reg && res_step_reg,
        (res_coil_reg[3] ^ res_coil_reg[2]) && (res_coil_reg[1] ^ res_coil_reg[0]))
    // a move beat while steps remain comes back rejected and still busy
    `STPSEQ_ASSERT_NEXT(a_reject_busy,
        in_fire && operation == OP_MOVE && remaining_reg != '0,
        out_valid_reg && res_reject_reg && res_busy_reg)

endmodule

`default_nettype wire
